FILE: src/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg - shared types and constants for the call list
// Item types, list entry layout, outcome codes, register map and sequencer
// states used by every file of the call list block except clt_ram.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int ADDR_W    = 7;
  localparam int AGE_W     = 16;
  localparam int OUTCOME_W = 3;
  localparam int OCOUNT_W  = 5;
  localparam int REG_W     = 32;
  localparam int PADDR_W   = 3;

  // register map (index = paddr[2])
  localparam logic REG_CANCEL  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic             CANCEL_RST  = 1'b1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd600;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ADDED     = 3'd0,
    OUT_REFRESHED = 3'd1,
    OUT_REMOVED   = 3'd2,
    OUT_FULL      = 3'd3,
    OUT_TICK      = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] call_address;
  } in_item_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [ADDR_W-1:0]    shown_address;
    logic                 blank;
    logic [OCOUNT_W-1:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // controls for the per-entry unit
  typedef struct packed {
    logic              tick;
    logic              cancel;
    logic              found;
    logic [ADDR_W-1:0] call_address;
    logic [AGE_W-1:0]  timeout;
  } unit_ctrl_t;

  typedef struct packed {
    logic   keep;
    logic   hit;
    entry_t entry;
  } unit_res_t;

endpackage

FILE: src/call_list_with_timeout_top.sv
// ----------------------------------------------------------------------------
// call_list_with_timeout_top - pending call list with per-entry timeout
//
// Usage: drive in_item with start high while busy is low to hand over one
// item: a call (mode 0) with its address, or a one-second tick (mode 1).
// busy rises at once and stays high while the list is walked. Exactly one
// result per item appears on out_item for a single cycle, marked by
// out_valid; the receiver cannot stall it, and busy is already low in that
// cycle so the next item may follow straight away.
// The walk is paced by the list RAM: every item reads each listed entry
// once through its single read port, and the shared entry unit rewrites
// the compacted list in the same pass. The next item can be accepted in
// the result cycle.
// Registers on the APB port: cancel_on_repeat at 0x0, timeout_seconds at
// 0x4; write them only while busy is low. Reset (rst_n low, synchronous)
// empties the list, sets the rotation to the first entry and loads the
// register defaults; the list RAM itself is not cleared.
// ----------------------------------------------------------------------------
module call_list_with_timeout_top
  import clt_pkg::*;
#(
  parameter int LIST_SIZE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // item channel
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  // result channel
  output logic               out_valid,
  output out_item_t          out_item,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  output logic [REG_W-1:0]   prdata,
  output logic               pready
);

  localparam int CW = $clog2(LIST_SIZE + 1);
  localparam int AW = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam int EW = $bits(entry_t);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]     wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]     proc_idx_r, proc_idx_nxt;
  logic              proc_v_r, proc_v_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     dp_r, dp_nxt;
  logic              mode_r, mode_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] shown_r, shown_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic              cancel_r;
  logic [AGE_W-1:0]  timeout_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [EW-1:0]     ram_rdata;

  unit_ctrl_t        unit_ctrl;
  unit_res_t         unit_res;

  logic              cfg_wr;
  logic [CW:0]       dp_inc;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cancel_r  <= CANCEL_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CANCEL:  cancel_r  <= pwdata[0];
        REG_TIMEOUT: timeout_r <= pwdata[AGE_W-1:0];
        default:     ;
      endcase
    end
  end

  // read back the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_CANCEL:  prdata = {{(REG_W-1){1'b0}}, cancel_r};
      REG_TIMEOUT: prdata = {{(REG_W-AGE_W){1'b0}}, timeout_r};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- list RAM
  clt_ram #(
    .WIDTH (EW),
    .DEPTH (LIST_SIZE)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- entry unit
  assign unit_ctrl.tick         = mode_r;
  assign unit_ctrl.cancel       = cancel_r;
  assign unit_ctrl.found        = found_r;
  assign unit_ctrl.call_address = addr_r;
  assign unit_ctrl.timeout      = timeout_r;

  clt_entry_unit u_entry_unit (
    .entry_i (entry_t'(ram_rdata)),
    .ctrl_i  (unit_ctrl),
    .res_o   (unit_res)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign dp_inc    = {1'b0, dp_r} + {{CW{1'b0}}, 1'b1};

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    proc_idx_nxt  = proc_idx_r;
    proc_v_nxt    = 1'b0;
    found_nxt     = found_r;
    count_nxt     = count_r;
    dp_nxt        = dp_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    shown_nxt     = shown_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wr_idx_r[AW-1:0];
    ram_wdata     = unit_res.entry;

    unique case (state_r)
      ST_IDLE: begin
        // take the item and start the pass from the head of the list
        if (start) begin
          mode_nxt   = in_item.mode;
          addr_nxt   = in_item.call_address;
          rd_idx_nxt = '0;
          wr_idx_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = (count_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next read
        if (rd_idx_r < count_r) begin
          ram_re       = 1'b1;
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = rd_idx_r;
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end
        // evaluate the entry that has come back and compact it in place
        if (proc_v_r) begin
          if (unit_res.hit) begin
            found_nxt = 1'b1;
          end
          if (mode_r && (proc_idx_r == dp_r)) begin
            shown_nxt = unit_res.entry.addr;
          end
          if (unit_res.keep) begin
            ram_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + CW'(1);
          end
        end
        if ((rd_idx_r == count_r) && !proc_v_r) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        out_item_nxt.blank         = 1'b0;
        out_item_nxt.shown_address = addr_r;
        if (mode_r) begin
          // tick: show the rotating entry, then advance the rotation
          out_item_nxt.outcome = OUT_TICK;
          if ((count_r == '0) || (dp_r >= count_r)) begin
            out_item_nxt.blank         = 1'b1;
            out_item_nxt.shown_address = '0;
          end else begin
            out_item_nxt.shown_address = shown_r;
          end
          if (count_r != '0) begin
            count_nxt = wr_idx_r;
            if ((dp_inc > {1'b0, count_r}) || (count_r == CW'(1))) begin
              dp_nxt = '0;
            end else begin
              dp_nxt = dp_inc[CW-1:0];
            end
          end
        end else begin
          // call: report the match, append a new entry, or report a full list
          dp_nxt = '0;
          if (found_r) begin
            out_item_nxt.outcome = cancel_r ? OUT_REMOVED : OUT_REFRESHED;
            count_nxt            = wr_idx_r;
          end else if (count_r < CW'(LIST_SIZE)) begin
            out_item_nxt.outcome = OUT_ADDED;
            ram_we               = 1'b1;
            ram_waddr            = count_r[AW-1:0];
            ram_wdata.addr       = addr_r;
            ram_wdata.age        = '0;
            count_nxt            = count_r + CW'(1);
          end else begin
            out_item_nxt.outcome = OUT_FULL;
          end
        end
        out_item_nxt.entry_count = OCOUNT_W'(count_nxt);
        state_nxt                = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      proc_v_r    <= 1'b0;
      found_r     <= 1'b0;
      count_r     <= '0;
      dp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      proc_v_r    <= proc_v_nxt;
      found_r     <= found_nxt;
      count_r     <= count_nxt;
      dp_r        <= dp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    mode_r     <= mode_nxt;
    addr_r     <= addr_nxt;
    shown_r    <= shown_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

FILE: src/clt_ram.sv
// ----------------------------------------------------------------------------
// clt_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module clt_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/clt_entry_unit.sv
// ----------------------------------------------------------------------------
// clt_entry_unit - per-entry compare and age unit
// Evaluates one list entry per cycle: matches it against the call, ages it
// on a tick and decides whether it stays in the compacted list.
// ----------------------------------------------------------------------------
module clt_entry_unit
  import clt_pkg::*;
(
  input  entry_t     entry_i,
  input  unit_ctrl_t ctrl_i,
  output unit_res_t  res_o
);

  logic [AGE_W:0] age_inc;
  logic           expire;
  logic           match;

  // age by one tick and compare against the timeout
  assign age_inc = {1'b0, entry_i.age} + {{AGE_W{1'b0}}, 1'b1};
  assign expire  = age_inc >= {1'b0, ctrl_i.timeout};
  assign match   = !ctrl_i.found && (entry_i.addr == ctrl_i.call_address);

  always_comb begin
    res_o.entry.addr = entry_i.addr;
    res_o.entry.age  = entry_i.age;
    res_o.keep       = 1'b1;
    res_o.hit        = 1'b0;
    if (ctrl_i.tick) begin
      // an expired entry drops out, the rest carry their new age
      res_o.entry.age = age_inc[AGE_W-1:0];
      res_o.keep      = !expire;
    end else if (match) begin
      // first match of the call: delete or clear its age
      res_o.hit       = 1'b1;
      res_o.keep      = !ctrl_i.cancel;
      res_o.entry.age = '0;
    end
  end

endmodule

FILE: test/call_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_list_checker - result predictor and comparator for the call list
// Watches the item, result and register ports, keeps its own copy of the
// pending call list and register settings, predicts the result of every
// accepted item and compares each result, field by field, in order.
// ----------------------------------------------------------------------------
module call_list_checker
  import clt_pkg::*;
#(
  parameter int LIST_SIZE = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]   pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 results_due
);

  // shadow of the list and the registers
  logic [ADDR_W-1:0] list_addr [LIST_SIZE];
  logic [AGE_W:0]    list_age  [LIST_SIZE];
  int unsigned       list_count;
  int unsigned       show_ptr;
  logic              cancel_mode;
  logic [AGE_W-1:0]  timeout_ticks;

  out_item_t due_results[$];

  // close the gap left by slot pos
  function automatic void drop_slot(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < list_count; k++) begin
      list_addr[k] = list_addr[k + 1];
      list_age[k]  = list_age[k + 1];
    end
    if (list_count > 0) list_count--;
  endfunction

  // update the shadow list for one item and return its result
  function automatic out_item_t step_call_list(input in_item_t item);
    out_item_t   res;
    bit          found;
    int unsigned i;
    res   = '0;
    found = 1'b0;
    if (!item.mode) begin
      res.shown_address = item.call_address;
      for (i = 0; i < list_count; i++) begin
        if (list_addr[i] == item.call_address) begin
          found = 1'b1;
          if (cancel_mode) begin
            drop_slot(i);
            res.outcome = OUT_REMOVED;
          end else begin
            list_age[i] = '0;
            res.outcome = OUT_REFRESHED;
          end
          break;
        end
      end
      if (!found) begin
        if (list_count < LIST_SIZE) begin
          list_addr[list_count] = item.call_address;
          list_age[list_count]  = '0;
          list_count++;
          res.outcome = OUT_ADDED;
        end else begin
          res.outcome = OUT_FULL;
        end
      end
      show_ptr = 0;
    end else begin
      res.outcome = OUT_TICK;
      if (list_count > 0) begin
        // show the next entry, or the blank slot past the last one
        if (show_ptr >= list_count) res.blank = 1'b1;
        else res.shown_address = list_addr[show_ptr];
        show_ptr++;
        if (show_ptr > list_count) show_ptr = 0;
        if (list_count == 1) show_ptr = 0;
        // age every entry; the one shifted into a freed slot is aged too
        i = 0;
        while (i < list_count) begin
          list_age[i] = list_age[i] + (AGE_W + 1)'(1);
          if (list_age[i] >= {1'b0, timeout_ticks}) begin
            list_age[i] = '0;
            drop_slot(i);
          end else begin
            i++;
          end
        end
      end else begin
        res.blank = 1'b1;
      end
    end
    res.entry_count = OCOUNT_W'(list_count);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_count    = 0;
      show_ptr      = 0;
      cancel_mode   = CANCEL_RST;
      timeout_ticks = TIMEOUT_RST;
      for (int k = 0; k < LIST_SIZE; k++) begin
        list_addr[k] = '0;
        list_age[k]  = '0;
      end
      due_results.delete();
      fail_count  = 0;
      results_due = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TIMEOUT) timeout_ticks = pwdata[AGE_W-1:0];
        else cancel_mode = pwdata[0];
      end
      // compare a result against the oldest prediction
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: outcome %0d address %0d",
                 out_item.outcome, out_item.shown_address);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_item.outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d",
                   want.outcome, out_item.outcome);
            fail_count++;
          end
          if (out_item.shown_address !== want.shown_address) begin
            $error("shown_address mismatch: expected %0d, actual %0d",
                   want.shown_address, out_item.shown_address);
            fail_count++;
          end
          if (out_item.blank !== want.blank) begin
            $error("blank mismatch: expected %0d, actual %0d",
                   want.blank, out_item.blank);
            fail_count++;
          end
          if (out_item.entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.entry_count, out_item.entry_count);
            fail_count++;
          end
        end
      end
      // predict the accepted item
      if (start && !busy) due_results.push_back(step_call_list(in_item));
      results_due = due_results.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - call list with timeout, top of the testbench
// Drives calls and one-second ticks through the command port and sets the
// repeat mode and timeout over APB between phases: a directed opening that
// covers empty, single, full and timeout cases, then random phases, all but
// the last with random gaps. The checker predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import clt_pkg::*;

  localparam int LIST_SIZE = 16;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_valid;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [REG_W-1:0]   pwdata;
  logic [REG_W-1:0]   prdata;
  logic               pready;
  int                 fail_count;
  int                 results_due;

  call_list_with_timeout_top #(.LIST_SIZE(LIST_SIZE)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  call_list_checker #(.LIST_SIZE(LIST_SIZE)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // hand over one item and hold it until accepted
  task automatic send_item(input logic is_tick, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    start                = 1'b1;
    in_item.mode         = is_tick;
    in_item.call_address = addr;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_call(input logic [ADDR_W-1:0] addr);
    send_item(1'b0, addr);
  endtask

  task automatic send_tick();
    send_item(1'b1, 7'($urandom_range(0, 127)));
  endtask

  // drop start for an idle gap set by n, with noise on the item
  task automatic idle_gap(input int n);
    @(negedge clk);
    start   = 1'b0;
    in_item = in_item_t'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // drain every outstanding result
  task automatic wait_quiet();
    @(negedge clk);
    start = 1'b0;
    while (results_due != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // APB write: setup then access
  task automatic reg_write(input logic idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_regs(input logic cancel, input logic [AGE_W-1:0] timeout);
    wait_quiet();
    reg_write(REG_CANCEL, {31'd0, cancel});
    reg_write(REG_TIMEOUT, {16'd0, timeout});
  endtask

  initial begin
    int                tick_pct;
    logic              cancel;
    logic [AGE_W-1:0]  timeout;
    logic [ADDR_W-1:0] addr;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list, single entry, address extremes, two entries expiring together
    set_regs(1'b1, 16'd3);
    send_tick();
    send_call(7'd127);
    send_tick();
    send_tick();
    send_tick();
    send_call(7'd0);
    send_call(7'd99);
    send_call(7'd0);
    send_call(7'd5);
    send_tick();
    send_tick();
    send_tick();

    // refresh on repeat, then a zero timeout empties the list
    set_regs(1'b0, 16'd0);
    send_call(7'd1);
    send_call(7'd2);
    send_call(7'd1);
    send_tick();

    // fill the list, then overflow it
    set_regs(1'b1, 16'hFFFF);
    for (int a = 10; a < 10 + LIST_SIZE; a++) send_call(7'(a));
    send_call(7'd42);
    send_tick();

    // random phases; the first two pin the timeout extremes
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        cancel  = 1'b1;
        timeout = 16'd1;
      end else if (phase == 1) begin
        cancel  = 1'b0;
        timeout = 16'hFFFF;
      end else begin
        cancel  = 1'($urandom_range(0, 1));
        timeout = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(20, 200))
                                              : 16'($urandom_range(2, 12));
      end
      set_regs(cancel, timeout);
      tick_pct = $urandom_range(15, 55);
      for (int n = 0; n < 52; n++) begin
        // mostly a small pool of addresses so that repeats are common
        addr = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(1, 24));
        if ($urandom_range(0, 99) < tick_pct) send_tick();
        else send_call(addr);
        // no idling in the last phase
        if (phase != 7 && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 14));
      end
    end

    wait_quiet();
    repeat (LIST_SIZE + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
